FILE: src/mbc_pkg.sv
package mbc_pkg;

  localparam logic [2:0] FUNC_MUL   = 3'd0;
  localparam logic [2:0] FUNC_MLA   = 3'd1;
  localparam logic [2:0] FUNC_UMULL = 3'd2;
  localparam logic [2:0] FUNC_UMLAL = 3'd3;
  localparam logic [2:0] FUNC_SMULL = 3'd4;
  localparam logic [2:0] FUNC_SMLAL = 3'd5;

  localparam logic [31:0] HI_CARRY_BIT = 32'h2000_0000;
  localparam logic [31:0] HI_ACC_BIAS  = 32'h0800_0000;
  localparam logic [31:0] HI_A2_BIT    = 32'h1000_0000;
  localparam logic [31:0] HI_A1_BIT    = 32'h4000_0000;
  localparam logic [31:0] HI_A1_SUM    = 32'h2000_0000;
  localparam logic [31:0] HI_A0_BIT    = 32'h4000_0000;

  localparam int NUM_STEPS = 12;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] multiplicand;
    logic [31:0] multiplier;
    logic [31:0] acc_low;
    logic [31:0] acc_high;
    logic        set_flags;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        flags_valid;
    logic        neg_flag;
    logic        zero_flag;
    logic        carry_flag;
    logic [3:0]  cycle_count;
  } out_word_t;

  typedef struct packed {
    logic [31:0] sum;
    logic [31:0] cur;
    logic [31:0] carry;
  } bs_t;

  typedef struct packed {
    logic        is_long;
    logic        setf;
    logic [31:0] rm;
    logic [31:0] rs;
    logic [31:0] acc_l;
    logic [31:0] acc_h;
    logic [31:0] pll;
    logic [31:0] plh;
    logic [31:0] phl;
    logic [31:0] phh;
    logic [31:0] corr;
    logic [32:0] mid;
    logic [63:0] prod;
    logic [63:0] res;
    bs_t         bs;
    logic        sgn;
    logic        c4;
    logic        c8;
    logic        hi_c;
    logic        full;
    logic [3:0]  cyc;
  } pipe_t;

  // radix-4 digit of window {b(n+1), b(n), b(n-1)} times md, weighted 2^n
  function automatic logic [31:0] booth_add(input logic [31:0] md, input logic [2:0] win,
                                            input int n);
    logic [31:0] v;
    case (win)
      3'b001, 3'b010: v = md;
      3'b011:         v = md << 1;
      3'b100:         v = 32'd0 - (md << 1);
      3'b101, 3'b110: v = 32'd0 - md;
      default:        v = 32'd0;
    endcase
    return v << n;
  endfunction

endpackage

FILE: src/mbc_bstep.sv
module mbc_bstep (
  input  mbc_pkg::bs_t  st,
  input  logic [31:0]   add,
  output mbc_pkg::bs_t  nx
);
  import mbc_pkg::*;

  logic [31:0] sum_next;

  assign sum_next = st.sum + add;
  assign nx.sum   = sum_next;
  assign nx.cur   = st.cur ^ st.carry ^ add;
  assign nx.carry = sum_next - (st.cur ^ st.carry ^ add);

endmodule

FILE: src/multiply_accumulate_with_booth_carry_core.sv
// channel | signals                          | word
// in      | in_valid, in_ready, in_data      | in_word_t
// out     | out_valid, out_ready, out_data   | out_word_t
// Fully pipelined: one word in per cycle while the output is not stalled.
// The 12-step Booth carry chain spans the stages, at most two per stage.
// Reset clears only the stage valid bits.
// A stalled output freezes every stage together; nothing is dropped.
module multiply_accumulate_with_booth_carry_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mbc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mbc_pkg::out_word_t out_data
);
  import mbc_pkg::*;

  localparam int NS = 6;

  logic      [NS:0]   vld;
  pipe_t              st      [NS];
  pipe_t              nx      [NS];
  out_word_t          out_next;
  bs_t                step_out[NUM_STEPS];
  bs_t                init_bs;
  logic               en;

  assign en        = !vld[NS] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NS];

  generate
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      localparam int SRC = (k == 0) ? 0 : (k - 1) / 2;
      logic [31:0] md_k;
      logic [31:0] mp_k;
      bs_t         bin;
      if (k == 0) begin : g_first
        assign md_k = in_data.multiplicand | 32'd1;
        assign mp_k = in_data.multiplier;
        assign bin  = init_bs;
      end else begin : g_rest
        assign md_k = st[SRC].rm | 32'd1;
        assign mp_k = st[SRC].rs;
        if (k % 2 == 1) begin : g_odd
          assign bin = st[SRC].bs;
        end else begin : g_even
          assign bin = step_out[k-1];
        end
      end
      mbc_bstep u_step (
        .st (bin),
        .add(booth_add(md_k, mp_k[2*k +: 3], 2*k + 1)),
        .nx (step_out[k])
      );
    end
  endgenerate

  always_comb begin
    logic [31:0] md0;
    logic [31:0] al;

    md0           = in_data.multiplicand | 32'd1;
    al            = in_data.func[0] ? in_data.acc_low : 32'd0;
    init_bs.carry = in_data.multiplier[0] ? (32'd0 - md0) : 32'd0;
    init_bs.sum   = init_bs.carry + al;
    init_bs.cur   = al;
  end

  always_comb begin
    logic        dl;
    logic        ac;
    logic        sg;
    logic [31:0] a;
    logic [31:0] b;
    logic [2:0]  m;
    logic [31:0] hmd;
    logic [6:0]  h;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] hacc;
    logic [31:0] hsum;
    logic        fits9;
    logic        fits17;
    logic        lc;
    logic        cf;
    logic        zf;
    logic        nf;
    pipe_t       s;

    a  = in_data.multiplicand;
    b  = in_data.multiplier;
    dl = (in_data.func inside {[FUNC_UMULL:FUNC_SMLAL]});
    ac = in_data.func[0];
    sg = !(in_data.func == FUNC_UMULL || in_data.func == FUNC_UMLAL);

    nx[0]         = '0;
    nx[0].is_long = dl;
    nx[0].setf    = in_data.set_flags;
    nx[0].sgn     = sg;
    nx[0].rm      = a;
    nx[0].rs      = b;
    nx[0].acc_l   = ac ? in_data.acc_low : 32'd0;
    nx[0].acc_h   = (ac && dl) ? in_data.acc_high : 32'd0;
    nx[0].pll     = a[15:0] * b[15:0];
    nx[0].plh     = a[15:0] * b[31:16];
    nx[0].phl     = a[31:16] * b[15:0];
    nx[0].phh     = a[31:16] * b[31:16];
    nx[0].corr    = ((sg && a[31]) ? b : 32'd0) + ((sg && b[31]) ? a : 32'd0);

    if (b[31:8] == 24'd0 || (sg && b[31:8] == 24'hFF_FFFF)) begin
      m = 3'd1;
    end else if (b[31:16] == 16'd0 || (sg && b[31:16] == 16'hFFFF)) begin
      m = 3'd2;
    end else if (b[31:24] == 8'd0 || (sg && b[31:24] == 8'hFF)) begin
      m = 3'd3;
    end else begin
      m = 3'd4;
    end
    nx[0].full = (m == 3'd4);
    nx[0].cyc  = {1'b0, m} + (dl ? (ac ? 4'd4 : 4'd3) : (ac ? 4'd3 : 4'd2));

    nx[0].bs      = step_out[0];

    s        = st[0];
    nx[1]    = s;
    nx[1].mid = {1'b0, s.plh} + {1'b0, s.phl};
    nx[1].bs  = step_out[2];
    hmd = (s.sgn ? {{6{s.rm[31]}}, s.rm[31:6]} : {6'd0, s.rm[31:6]}) | 32'd1;
    h   = {s.sgn & s.rs[31], s.rs[31:26]};
    a2  = booth_add(hmd, h[2:0], 1);
    a1  = booth_add(hmd, h[4:2], 3);
    a0  = booth_add(hmd, h[6:4], 5);
    hacc = s.acc_h - HI_ACC_BIAS - (a2 & HI_A2_BIT) - (a1 & HI_A1_BIT);
    hsum = hacc + (a1 & HI_A1_SUM) + (a0 & HI_A0_BIT);
    hacc = hacc - (~s.acc_h & HI_CARRY_BIT);
    nx[1].hi_c = hsum[31] ^ hacc[31];

    nx[2]      = st[1];
    nx[2].prod = {st[1].phh, st[1].pll} + {15'd0, st[1].mid, 16'd0};
    nx[2].bs   = step_out[4];
    nx[2].c4   = step_out[3].carry[31];

    nx[3]     = st[2];
    nx[3].res = st[2].prod - {st[2].corr, 32'd0} + {st[2].acc_h, st[2].acc_l};
    nx[3].bs  = step_out[6];

    nx[4]    = st[3];
    nx[4].bs = step_out[8];
    nx[4].c8 = step_out[7].carry[31];

    nx[5]    = st[4];
    nx[5].bs = step_out[10];

    s      = st[5];
    fits9  = (s.rs[31:8] == 24'd0) || (s.rs[31:8] == 24'hFF_FFFF);
    fits17 = (s.rs[31:16] == 16'd0) || (s.rs[31:16] == 16'hFFFF);
    lc     = fits9 ? s.c4 : (fits17 ? s.c8 : step_out[11].carry[31]);
    cf     = !s.full ? lc : (!s.is_long ? (s.rs[31:30] == 2'b10) : s.hi_c);
    zf     = s.is_long ? (s.res == 64'd0) : (s.res[31:0] == 32'd0);
    nf     = s.is_long ? s.res[63] : s.res[31];

    out_next.result_low  = s.res[31:0];
    out_next.result_high = s.is_long ? s.res[63:32] : 32'd0;
    out_next.flags_valid = s.setf;
    out_next.neg_flag    = s.setf && nf;
    out_next.zero_flag   = s.setf && zf;
    out_next.carry_flag  = s.setf && cf;
    out_next.cycle_count = s.cyc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        st[i] <= nx[i];
      end
      out_data <= out_next;
    end
  end

endmodule
